### sv/stl_pkg.sv
// Shared types and constants for the sorted time list.
// No dependencies; used by every module of the block.
package stl_pkg;

   localparam int DEPTH   = 16;
   localparam int TIME_W  = 12;
   localparam int TAG_W   = 16;
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;

   // count register holds 0..DEPTH
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SLOT_W = $clog2(DEPTH);
   // common width for index / count arithmetic
   localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_REVERSE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ    = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [TIME_W-1:0]  entry_time;
      logic [TAG_W-1:0]   entry_tag;
      logic [INDEX_W-1:0] index;
   } stl_req_type;

   typedef struct packed {
      logic               found;
      logic [TIME_W-1:0]  out_time;
      logic [TAG_W-1:0]   out_tag;
      logic [COUNT_W-1:0] count;
      logic               dropped;
   } stl_rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic              ins;
      logic [TIME_W-1:0] entry_time;
      logic [TAG_W-1:0]  entry_tag;
   } stl_cmd_type;

   // where a cell sits relative to the fill level
   typedef struct packed {
      logic occ;    // cell holds an entry
      logic open;   // cell index <= count
   } stl_pos_type;

   // handed from a cell to its right neighbor
   typedef struct packed {
      logic              lt;   // held and strictly earlier than new entry
      logic [TIME_W-1:0] entry_time;
      logic [TAG_W-1:0]  entry_tag;
   } stl_link_type;

endpackage

### sv/stl_cell.sv
// One slot of the sorted list: holds an entry, compares it with the
// entry being inserted, and either keeps it, takes the new one or shifts in
// its left neighbor's entry. Depends on stl_pkg.
module stl_cell import stl_pkg::*; (
   input  logic         clock,
   input  stl_cmd_type  cmd,
   input  stl_pos_type  pos,
   input  stl_link_type left,
   output stl_link_type right
);

   logic [TIME_W-1:0] time_ff, time_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              lt;
   logic              take_new;
   logic              take_left;

   assign lt = pos.occ && (time_ff < cmd.entry_time);

   // new entry lands at the first cell not earlier than it
   assign take_new  = cmd.ins && pos.open && !lt && left.lt;
   assign take_left = cmd.ins && pos.open && !left.lt;

   always_comb begin
      time_in = time_ff;
      tag_in  = tag_ff;
      if (take_new) begin
         time_in = cmd.entry_time;
         tag_in  = cmd.entry_tag;
      end else if (take_left) begin
         time_in = left.entry_time;
         tag_in  = left.entry_tag;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      tag_ff  <= tag_in;
   end

   assign right.lt         = lt;
   assign right.entry_time = time_ff;
   assign right.entry_tag  = tag_ff;

endmodule

### sv/sorted_time_list_top.sv
// Sorted time list: bounded list of (time, tag) entries kept ascending by
// time, with insert, reverse-read-order and read-at-index operations. Every
// transaction returns one result transaction in the next cycle from an output
// register; a new request is taken each cycle while the result register is
// empty or being drained. An insert updates the whole row of cells together,
// each cell comparing its entry with the new one and shifting from its
// neighbor. Reads select one cell through a mux.
// Depends on stl_pkg and stl_cell.
module sorted_time_list_top import stl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  stl_req_type req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output stl_rsp_type rsp
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             reversed_ff, reversed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   stl_rsp_type      rsp_ff, rsp_in;

   logic         accept;
   logic         full;
   stl_cmd_type  cmd;
   stl_pos_type  pos [DEPTH];
   stl_link_type link [DEPTH+1];

   logic [WIDE_W-1:0] count_w;
   logic [WIDE_W-1:0] index_w;
   logic [WIDE_W-1:0] slot_w;
   logic              hit;
   logic [TIME_W-1:0] rd_time;
   logic [TAG_W-1:0]  rd_tag;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CNT_W'(DEPTH));

   assign cmd.ins        = accept && (req.func == FN_INSERT) && !full;
   assign cmd.entry_time = req.entry_time;
   assign cmd.entry_tag  = req.entry_tag;

   // head of the chain: nothing to the left, new entry may land in cell 0
   assign link[0].lt         = 1'b1;
   assign link[0].entry_time = req.entry_time;
   assign link[0].entry_tag  = req.entry_tag;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign pos[i].occ  = (count_ff >  CNT_W'(i));
      assign pos[i].open = (count_ff >= CNT_W'(i));

      stl_cell u_cell (
         .clock (clock),
         .cmd   (cmd),
         .pos   (pos[i]),
         .left  (link[i]),
         .right (link[i+1])
      );
   end

   // read path
   assign count_w = WIDE_W'(count_ff);
   assign index_w = WIDE_W'(req.index);
   assign hit     = (index_w < count_w);
   assign slot_w  = reversed_ff ? (count_w - WIDE_W'(1) - index_w) : index_w;

   always_comb begin
      rd_time = '0;
      rd_tag  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (slot_w[SLOT_W-1:0] == SLOT_W'(i)) begin
            rd_time = link[i+1].entry_time;
            rd_tag  = link[i+1].entry_tag;
         end
      end
   end

   always_comb begin
      count_in    = count_ff;
      reversed_in = reversed_ff;
      rsp_in      = '0;
      case (req.func)
         FN_INSERT: begin
            if (full) begin
               rsp_in.dropped = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         FN_REVERSE: begin
            if (count_ff >= CNT_W'(2)) begin
               reversed_in = !reversed_ff;
            end
         end
         FN_READ: begin
            if (hit) begin
               rsp_in.found    = 1'b1;
               rsp_in.out_time = rd_time;
               rsp_in.out_tag  = rd_tag;
            end
         end
         default: begin
         end
      endcase
      rsp_in.count = COUNT_W'(WIDE_W'(count_in));
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         reversed_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff    <= count_in;
            reversed_ff <= reversed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

### sv/stl_checker.sv
// Port-level checks for the sorted time list, bound to the top level.
// Depends on stl_pkg and sorted_time_list_top.
module stl_checker import stl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input stl_rsp_type rsp
);

   // a result not held over from a stalled cycle must follow an accepted request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && rsp_stall) |-> $past(req_valid && !req_stall))
      else $error("result without request");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.dropped |-> rsp.count == COUNT_W'(DEPTH) && !rsp.found)
      else $error("drop while not full");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.found |-> rsp.out_time == '0 && rsp.out_tag == '0)
      else $error("miss carries data");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.found |-> rsp.count != '0)
      else $error("hit on empty list");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind sorted_time_list_top stl_checker u_stl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
